[hdl/rdiv_pkg.sv]
// ----------------------------------------------------------------------------
// Restoring divider package
// Shared widths, mode codes and pipeline types for the restoring divider.
// ----------------------------------------------------------------------------
package rdiv_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int MODE_WIDTH = 2;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_UQUO = 2'd0,
      MODE_UREM = 2'd1,
      MODE_SQUO = 2'd2,
      MODE_SREM = 2'd3
   } mode_type;

   typedef struct packed {
      logic want_rem;
      logic neg_quo;
      logic neg_rem;
      logic div_zero;
   } ctrl_type;

endpackage

[hdl/rdiv_stage.sv]
// ----------------------------------------------------------------------------
// Restoring divider step stage
// One registered pipeline stage that resolves one quotient bit.
// ----------------------------------------------------------------------------
module rdiv_stage
   import rdiv_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  ctrl_type              in_ctrl,
   input  logic [DATA_WIDTH-1:0] in_rem,
   input  logic [DATA_WIDTH-1:0] in_quo,
   input  logic [DATA_WIDTH-1:0] in_div,
   output logic                  out_valid,
   output ctrl_type              out_ctrl,
   output logic [DATA_WIDTH-1:0] out_rem,
   output logic [DATA_WIDTH-1:0] out_quo,
   output logic [DATA_WIDTH-1:0] out_div
);

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;
   logic                  valid_ff;
   ctrl_type              ctrl_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] div_ff;

   always_comb begin
      shifted = {in_rem, in_quo[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, in_div};
      fits    = ~diff[DATA_WIDTH];
      rem_in  = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_in  = {in_quo[DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         ctrl_ff <= in_ctrl;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         div_ff  <= in_div;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_div   = div_ff;

endmodule

[hdl/restoring_integer_divider_core.sv]
// ----------------------------------------------------------------------------
// Restoring integer divider core
// Pipelined radix-2 restoring divider for signed and unsigned quotient or
// remainder.
// ----------------------------------------------------------------------------
//   channel | ports                                   | direction
//   request | req_valid req_ready req_mode req_dividend req_divisor | in
//   response| rsp_valid rsp_ready rsp_result           | out
//
// A transaction passes through DATA_WIDTH + 2 register stages: sign
// conditioning, one stage per quotient bit, and sign fixing. A new
// transaction can enter every cycle while the response is not stalled.
// Reset clears all stage valid bits. A stalled response freezes the whole
// pipeline; nothing is lost or repeated.
module restoring_integer_divider_core
   import rdiv_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_WIDTH-1:0] req_mode,
   input  logic [DATA_WIDTH-1:0] req_dividend,
   input  logic [DATA_WIDTH-1:0] req_divisor,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_result
);

   localparam int STEPS = DATA_WIDTH;

   logic advance;
   logic is_signed, a_neg, b_neg;
   logic [DATA_WIDTH-1:0] a_mag, b_mag;

   logic                  v   [0:STEPS];
   ctrl_type              c   [0:STEPS];
   logic [DATA_WIDTH-1:0] rem [0:STEPS];
   logic [DATA_WIDTH-1:0] quo [0:STEPS];
   logic [DATA_WIDTH-1:0] dv  [0:STEPS];

   logic                  v0_ff;
   ctrl_type              c0_ff, c0_in;
   logic [DATA_WIDTH-1:0] a_ff, b_ff;
   logic                  out_valid_ff;
   logic [DATA_WIDTH-1:0] result_ff, result_in;

   assign advance   = ~out_valid_ff | rsp_ready;
   assign req_ready = advance;

   always_comb begin
      is_signed        = (req_mode == MODE_SQUO) || (req_mode == MODE_SREM);
      a_neg            = is_signed & req_dividend[DATA_WIDTH-1];
      b_neg            = is_signed & req_divisor[DATA_WIDTH-1];
      a_mag            = a_neg ? (~req_dividend + 1'b1) : req_dividend;
      b_mag            = b_neg ? (~req_divisor + 1'b1) : req_divisor;
      c0_in.want_rem   = (req_mode == MODE_UREM) || (req_mode == MODE_SREM);
      c0_in.neg_quo    = a_neg ^ b_neg;
      c0_in.neg_rem    = a_neg;
      c0_in.div_zero   = (req_divisor == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
      if (advance) begin
         c0_ff <= c0_in;
         a_ff  <= a_mag;
         b_ff  <= b_mag;
      end
   end

   assign v[0]   = v0_ff;
   assign c[0]   = c0_ff;
   assign rem[0] = '0;
   assign quo[0] = a_ff;
   assign dv[0]  = b_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      rdiv_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (v[i]),
         .in_ctrl   (c[i]),
         .in_rem    (rem[i]),
         .in_quo    (quo[i]),
         .in_div    (dv[i]),
         .out_valid (v[i+1]),
         .out_ctrl  (c[i+1]),
         .out_rem   (rem[i+1]),
         .out_quo   (quo[i+1]),
         .out_div   (dv[i+1])
      );
   end

   always_comb begin
      priority if (c[STEPS].div_zero) begin
         result_in = '0;
      end else if (c[STEPS].want_rem) begin
         result_in = c[STEPS].neg_rem ? (~rem[STEPS] + 1'b1) : rem[STEPS];
      end else begin
         result_in = c[STEPS].neg_quo ? (~quo[STEPS] + 1'b1) : quo[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= v[STEPS];
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;

endmodule

[hdl/restoring_integer_divider_core_checker.sv]
// ----------------------------------------------------------------------------
// Restoring divider port checker
// Concurrent checks on the port behavior of the divider core.
// ----------------------------------------------------------------------------
module restoring_integer_divider_core_checker
   import rdiv_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_result
);

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("Request side stalled while the response side was free.");

   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("Request accepted while the pipeline was frozen.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result)))
      else $error("Stalled response transaction changed.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid directly after reset.");

endmodule

bind restoring_integer_divider_core restoring_integer_divider_core_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_result (rsp_result)
);
